FILE: hw/rtl/ssi_pkg.sv
package ssi_pkg;

    localparam int COORD_WIDTH = 24;
    // widths of the exact intermediate values
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int SPLIT_W = (CROSS_W + 1) / 2;
    localparam int HI_W    = CROSS_W - SPLIT_W;
    localparam int PLO_W   = SPLIT_W + 1 + DIFF_W;
    localparam int PHI_W   = HI_W + 1 + DIFF_W;
    localparam int NUM_W   = CROSS_W + DIFF_W;
    localparam int REM_W   = CROSS_W;
    localparam int Q_W     = COORD_WIDTH;

    // one axis of the divider chain
    typedef struct packed {
        logic [REM_W-1:0]       rem;
        logic [Q_W-1:0]         rest;
        logic [Q_W-1:0]         quo;
        logic                   neg;
        logic [COORD_WIDTH-1:0] base;
    } t_lane;

    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [REM_W-1:0] den;
    } t_side;

    typedef struct packed {
        t_side side;
        t_lane lx;
        t_lane ly;
    } t_cell_data;

endpackage

FILE: hw/rtl/ssi_front.sv
module ssi_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_p1x,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_p1y,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_p2x,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_p2y,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_sx,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_sy,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_ex,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_ey,
    output ssi_pkg::t_cell_data                  o_data
);

    localparam int CW = ssi_pkg::COORD_WIDTH;
    localparam int DW = ssi_pkg::DIFF_W;
    localparam int PW = ssi_pkg::PROD_W;
    localparam int XW = ssi_pkg::CROSS_W;
    localparam int SW = ssi_pkg::SPLIT_W;
    localparam int HW = ssi_pkg::HI_W;
    localparam int LW = ssi_pkg::PLO_W;
    localparam int GW = ssi_pkg::PHI_W;
    localparam int NW = ssi_pkg::NUM_W;
    localparam int RW = ssi_pkg::REM_W;
    localparam int QW = ssi_pkg::Q_W;

    logic [5:0] r_v;

    // stage 1: differences
    logic signed [DW-1:0] r_pdx, r_pdy, r_ldx, r_ldy, r_ox, r_oy;
    logic signed [CW-1:0] r_b1x, r_b1y;
    // stage 2: products
    logic signed [PW-1:0] r_m0, r_m1, r_m2, r_m3, r_m4, r_m5;
    logic signed [DW-1:0] r_d2x, r_d2y;
    logic signed [CW-1:0] r_b2x, r_b2y;
    // stage 3: cross product and numerators
    logic signed [XW-1:0] r_cp, r_sn, r_tn;
    logic signed [DW-1:0] r_d3x, r_d3y;
    logic signed [CW-1:0] r_b3x, r_b3y;
    // stage 4: sign normalised
    logic [XW-1:0]        r_den4, r_tn4;
    logic                 r_hit4;
    logic signed [DW-1:0] r_d4x, r_d4y;
    logic signed [CW-1:0] r_b4x, r_b4y;
    // stage 5: partial products
    logic signed [LW-1:0] r_lox, r_loy;
    logic signed [GW-1:0] r_hix, r_hiy;
    logic [XW-1:0]        r_den5;
    logic                 r_hit5;
    logic signed [CW-1:0] r_b5x, r_b5y;
    // stage 6: full products
    logic signed [NW-1:0] r_nx, r_ny;
    logic [XW-1:0]        r_den6;
    logic                 r_hit6;
    logic signed [CW-1:0] r_b6x, r_b6y;
    // stage 7: magnitudes
    ssi_pkg::t_cell_data  r_out;

    logic signed [XW-1:0] n_cpa, n_sna, n_tna;
    logic                 n_neg;
    logic signed [SW:0]   n_tlo;
    logic signed [HW:0]   n_thi;
    logic signed [NW-1:0] n_nx, n_ny;
    logic [NW-1:0]        n_mx, n_my;

    always_comb begin
        n_neg = r_cp[XW-1];
        n_cpa = n_neg ? -r_cp : r_cp;
        n_sna = n_neg ? -r_sn : r_sn;
        n_tna = n_neg ? -r_tn : r_tn;
        n_tlo = $signed({1'b0, r_tn4[SW-1:0]});
        n_thi = $signed({1'b0, r_tn4[XW-1:SW]});
        n_nx  = NW'(r_lox) + (NW'(r_hix) <<< SW);
        n_ny  = NW'(r_loy) + (NW'(r_hiy) <<< SW);
        n_mx  = r_nx[NW-1] ? NW'(-r_nx) : NW'(r_nx);
        n_my  = r_ny[NW-1] ? NW'(-r_ny) : NW'(r_ny);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
            r_out.side.valid <= 1'b0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};

            r_pdx <= DW'(i_p2x) - DW'(i_p1x);
            r_pdy <= DW'(i_p2y) - DW'(i_p1y);
            r_ldx <= DW'(i_ex) - DW'(i_sx);
            r_ldy <= DW'(i_ey) - DW'(i_sy);
            r_ox  <= DW'(i_p1x) - DW'(i_sx);
            r_oy  <= DW'(i_p1y) - DW'(i_sy);
            r_b1x <= i_p1x;
            r_b1y <= i_p1y;

            r_m0  <= r_pdx * r_ldy;
            r_m1  <= r_ldx * r_pdy;
            r_m2  <= r_pdx * r_oy;
            r_m3  <= r_pdy * r_ox;
            r_m4  <= r_ldx * r_oy;
            r_m5  <= r_ldy * r_ox;
            r_d2x <= r_pdx;
            r_d2y <= r_pdy;
            r_b2x <= r_b1x;
            r_b2y <= r_b1y;

            r_cp  <= XW'(r_m0) - XW'(r_m1);
            r_sn  <= XW'(r_m2) - XW'(r_m3);
            r_tn  <= XW'(r_m4) - XW'(r_m5);
            r_d3x <= r_d2x;
            r_d3y <= r_d2y;
            r_b3x <= r_b2x;
            r_b3y <= r_b2y;

            r_den4 <= n_cpa;
            r_tn4  <= n_tna;
            r_hit4 <= (r_cp != '0) && !n_sna[XW-1] && !n_tna[XW-1]
                      && (n_sna <= n_cpa) && (n_tna <= n_cpa);
            r_d4x  <= r_d3x;
            r_d4y  <= r_d3y;
            r_b4x  <= r_b3x;
            r_b4y  <= r_b3y;

            r_lox  <= n_tlo * r_d4x;
            r_loy  <= n_tlo * r_d4y;
            r_hix  <= n_thi * r_d4x;
            r_hiy  <= n_thi * r_d4y;
            r_den5 <= r_den4;
            r_hit5 <= r_hit4;
            r_b5x  <= r_b4x;
            r_b5y  <= r_b4y;

            r_nx   <= n_nx;
            r_ny   <= n_ny;
            r_den6 <= r_den5;
            r_hit6 <= r_hit5;
            r_b6x  <= r_b5x;
            r_b6y  <= r_b5y;

            r_out.side.valid <= r_v[5];
            r_out.side.hit   <= r_hit6;
            r_out.side.den   <= RW'(r_den6);
            r_out.lx.rem     <= n_mx[QW+RW-1:QW];
            r_out.lx.rest    <= n_mx[QW-1:0];
            r_out.lx.quo     <= '0;
            r_out.lx.neg     <= r_nx[NW-1];
            r_out.lx.base    <= r_b6x;
            r_out.ly.rem     <= n_my[QW+RW-1:QW];
            r_out.ly.rest    <= n_my[QW-1:0];
            r_out.ly.quo     <= '0;
            r_out.ly.neg     <= r_ny[NW-1];
            r_out.ly.base    <= r_b6y;
        end
    end

    assign o_data = r_out;

endmodule

FILE: hw/rtl/ssi_div_cell.sv
module ssi_div_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  ssi_pkg::t_cell_data i_data,
    output ssi_pkg::t_cell_data o_data
);

    localparam int RW = ssi_pkg::REM_W;
    localparam int QW = ssi_pkg::Q_W;

    ssi_pkg::t_cell_data r_data;
    ssi_pkg::t_cell_data n_data;

    // one restoring step: bring down the next numerator bit, subtract if it fits
    function automatic ssi_pkg::t_lane f_step(ssi_pkg::t_lane l, logic [RW-1:0] den);
        logic [RW:0]    trial;
        logic [RW:0]    diff;
        ssi_pkg::t_lane o;
        trial = {l.rem, l.rest[QW-1]};
        diff  = trial - {1'b0, den};
        o      = l;
        o.rest = l.rest << 1;
        if (trial >= {1'b0, den}) begin
            o.rem = diff[RW-1:0];
            o.quo = {l.quo[QW-2:0], 1'b1};
        end else begin
            o.rem = trial[RW-1:0];
            o.quo = {l.quo[QW-2:0], 1'b0};
        end
        return o;
    endfunction

    always_comb begin
        n_data    = i_data;
        n_data.lx = f_step(i_data.lx, i_data.side.den);
        n_data.ly = f_step(i_data.ly, i_data.side.den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data.side.valid <= 1'b0;
        end else if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

FILE: hw/rtl/segment_segment_intersection.sv
// an accepted input beat passes through the front end, the divider chain and the output register to its result beat
// throughput: one beat per cycle; the whole pipeline holds only while the output register
//   is full and stalled, so i_stall reaches o_stall in the same cycle
// the divider is a chain of COORD_WIDTH cells, one quotient bit per cell per axis
// reset: synchronous active-low i_rst_n clears every valid bit; no clearing pass
module segment_segment_intersection (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_first_start_x,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_first_start_y,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_first_end_x,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_first_end_y,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_seg_start_x,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_seg_start_y,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_seg_end_x,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_seg_end_y,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_hit,
    output logic signed [ssi_pkg::COORD_WIDTH-1:0] o_hit_x,
    output logic signed [ssi_pkg::COORD_WIDTH-1:0] o_hit_y
);

    localparam int CW = ssi_pkg::COORD_WIDTH;
    localparam int QW = ssi_pkg::Q_W;

    // pipeline advance: held only when a finished beat sits unconsumed
    logic en;

    // chain links: entry 0 is the front end output, entry QW the last cell
    ssi_pkg::t_cell_data chain [QW+1];

    logic                 r_valid;
    logic                 r_hit;
    logic signed [CW-1:0] r_x, r_y;

    logic signed [QW:0]   n_qx, n_qy;

    assign en      = !(r_valid && i_stall);
    assign o_stall = !en;

    // differences, cross products, sign normalisation, range test and t*delta product
    ssi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_p1x   (i_first_start_x),
        .i_p1y   (i_first_start_y),
        .i_p2x   (i_first_end_x),
        .i_p2y   (i_first_end_y),
        .i_sx    (i_seg_start_x),
        .i_sy    (i_seg_start_y),
        .i_ex    (i_seg_end_x),
        .i_ey    (i_seg_end_y),
        .o_data  (chain[0])
    );

    // row of divider cells, each resolving one quotient bit for both axes
    for (genvar g = 0; g < QW; g++) begin : g_cell
        ssi_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_data  (chain[g]),
            .o_data  (chain[g+1])
        );
    end

    // restore the sign of the truncated quotient and offset from the first start point
    always_comb begin
        n_qx = chain[QW].lx.neg ? -$signed({1'b0, chain[QW].lx.quo})
                                : $signed({1'b0, chain[QW].lx.quo});
        n_qy = chain[QW].ly.neg ? -$signed({1'b0, chain[QW].ly.quo})
                                : $signed({1'b0, chain[QW].ly.quo});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= chain[QW].side.valid;
            r_hit   <= chain[QW].side.hit;
            // a miss or a parallel pair reports the origin
            r_x     <= chain[QW].side.hit
                       ? CW'($signed(chain[QW].lx.base) + CW'(n_qx)) : '0;
            r_y     <= chain[QW].side.hit
                       ? CW'($signed(chain[QW].ly.base) + CW'(n_qy)) : '0;
        end
    end

    assign o_valid = r_valid;
    assign o_hit   = r_hit;
    assign o_hit_x = r_x;
    assign o_hit_y = r_y;

    // a miss never reports a point
    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_hit_x == '0 && o_hit_y == '0))
        else $error("miss beat with nonzero point");

    // on a valid hit beat the last cell leaves a remainder below the divisor
    a_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (chain[QW].side.valid && chain[QW].side.hit)
        |-> (chain[QW].lx.rem < chain[QW].side.den && chain[QW].ly.rem < chain[QW].side.den))
        else $error("divider remainder out of range");

    // a held pipeline keeps the valid bit of the last cell frozen
    a_chain_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && $past(i_rst_n)) |=> $stable(chain[QW].side.valid))
        else $error("divider chain moved while held");

endmodule

FILE: tb/ssi_checker.sv
`timescale 1ns / 1ps

module ssi_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic                                   i_in_stall,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_first_start_x,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_first_start_y,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_first_end_x,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_first_end_y,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_seg_start_x,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_seg_start_y,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_seg_end_x,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_seg_end_y,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_stall,
    input  logic                                   i_hit,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_hit_x,
    input  logic signed [ssi_pkg::COORD_WIDTH-1:0] i_hit_y,
    output int                                     o_fail_count,
    output int                                     o_pending
);

    typedef logic signed [ssi_pkg::COORD_WIDTH-1:0] t_coord;
    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic   hit;
        t_coord x;
        t_coord y;
    } t_crossing;

    t_crossing expected_hits[$];
    int        fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_hits.size();

    function automatic t_crossing predict_crossing(t_coord fsx, t_coord fsy, t_coord fex,
                                                   t_coord fey, t_coord ssx, t_coord ssy,
                                                   t_coord sex, t_coord sey);
        t_wide     pdx, pdy, ldx, ldy, ox, oy, cp, sn, tn, px, py;
        t_crossing r;
        pdx = t_wide'(fex) - t_wide'(fsx);
        pdy = t_wide'(fey) - t_wide'(fsy);
        ldx = t_wide'(sex) - t_wide'(ssx);
        ldy = t_wide'(sey) - t_wide'(ssy);
        ox  = t_wide'(fsx) - t_wide'(ssx);
        oy  = t_wide'(fsy) - t_wide'(ssy);
        cp  = pdx * ldy - ldx * pdy;
        sn  = pdx * oy - pdy * ox;
        tn  = ldx * oy - ldy * ox;
        r   = '0;
        if (cp == 0) return r;
        if (cp < 0) begin
            cp = -cp;
            sn = -sn;
            tn = -tn;
        end
        if (sn < 0 || sn > cp || tn < 0 || tn > cp) return r;
        // signed division truncates toward zero
        px = t_wide'(fsx) + (tn * pdx) / cp;
        py = t_wide'(fsy) + (tn * pdy) / cp;
        r.hit = 1'b1;
        r.x   = px[ssi_pkg::COORD_WIDTH-1:0];
        r.y   = py[ssi_pkg::COORD_WIDTH-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t: %s is %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_crossing want;
        if (i_rst_n && i_valid && !i_in_stall)
            expected_hits.push_back(predict_crossing(i_first_start_x, i_first_start_y,
                i_first_end_x, i_first_end_y, i_seg_start_x, i_seg_start_y,
                i_seg_end_x, i_seg_end_y));
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (expected_hits.size() == 0) begin
                report_mismatch("unexpected beat, hit", i_hit, 0);
            end else begin
                want = expected_hits.pop_front();
                if (i_hit !== want.hit) report_mismatch("hit", i_hit, want.hit);
                if (i_hit_x !== want.x) report_mismatch("hit_x", i_hit_x, want.x);
                if (i_hit_y !== want.y) report_mismatch("hit_y", i_hit_y, want.y);
            end
        end
    end

endmodule

FILE: tb/segment_segment_intersection_test.sv
`timescale 1ns / 1ps

module segment_segment_intersection_test;

    typedef logic signed [ssi_pkg::COORD_WIDTH-1:0] t_coord;

    localparam t_coord CMAX       = {1'b0, {(ssi_pkg::COORD_WIDTH-1){1'b1}}};
    localparam t_coord CMIN       = {1'b1, {(ssi_pkg::COORD_WIDTH-1){1'b0}}};
    localparam int     RAND_ITEMS = 1130;
    localparam int     IDLE_LIMIT = 2000;   // well beyond the long hold-off plus latency
    localparam int     HOLD_CYCLES = 300;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;
    logic   in_valid = 1'b0;
    logic   in_stall;
    logic   out_valid;
    logic   out_stall = 1'b0;
    logic   hit;
    t_coord hit_x, hit_y;
    t_coord fsx = '0, fsy = '0, fex = '0, fey = '0;
    t_coord ssx = '0, ssy = '0, sex = '0, sey = '0;
    int     fail_count, pending;
    int     idle_cycles = 0;
    int     results_taken = 0;

    always #6 clk = ~clk;

    segment_segment_intersection dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_first_start_x(fsx), .i_first_start_y(fsy),
        .i_first_end_x(fex), .i_first_end_y(fey),
        .i_seg_start_x(ssx), .i_seg_start_y(ssy),
        .i_seg_end_x(sex), .i_seg_end_y(sey),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_hit(hit), .o_hit_x(hit_x), .o_hit_y(hit_y)
    );

    ssi_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_in_stall(in_stall),
        .i_first_start_x(fsx), .i_first_start_y(fsy),
        .i_first_end_x(fex), .i_first_end_y(fey),
        .i_seg_start_x(ssx), .i_seg_start_y(ssy),
        .i_seg_end_x(sex), .i_seg_end_y(sey),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_hit(hit), .i_hit_x(hit_x), .i_hit_y(hit_y),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // watchdog: any cycle without a beat on either side counts toward the limit
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // sender gap: bursts with no gaps now and then
    function automatic int draw_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 13);
    endfunction

    // coordinate of random magnitude: full range keeps every bit toggling,
    // small spans give many real crossings
    function automatic t_coord rand_coord(int span_bits);
        t_coord v;
        v = t_coord'($urandom);
        return v >>> (ssi_pkg::COORD_WIDTH - span_bits);
    endfunction

    // one input beat: drive at the falling edge, hold until accepted
    task automatic send_pair(t_coord a, t_coord b, t_coord c, t_coord d,
                             t_coord e, t_coord f, t_coord g, t_coord h);
        int gap;
        @(negedge clk);
        fsx <= a; fsy <= b; fex <= c; fey <= d;
        ssx <= e; ssy <= f; sex <= g; sey <= h;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        gap = draw_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // receiver: random stall per beat, one long hold-off to back the pipe up
    initial begin
        int n;
        @(posedge rst_n);
        forever begin
            if (results_taken == 200) n = HOLD_CYCLES;
            else if ($urandom_range(0, 3) == 0) n = 0;
            else n = $urandom_range(0, 13);
            if (n > 0) begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
                @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!out_valid);
            results_taken++;
        end
    end

    initial begin
        int     span, kind;
        t_coord a, b, c, d, e, f, g, h;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // plain crossing at the middle
        send_pair(0, 0, 256, 256, 0, 256, 256, 0);
        // parallel, no hit
        send_pair(0, 0, 256, 0, 0, 256, 256, 256);
        // collinear and overlapping
        send_pair(0, 0, 512, 0, 256, 0, 768, 0);
        // zero-length first segment, then zero-length second
        send_pair(100, 100, 100, 100, 0, 0, 300, 300);
        send_pair(0, 0, 300, 300, 100, 100, 100, 100);
        // endpoint touches at both ends of each parameter
        send_pair(0, 0, 256, 0, 0, 0, 0, 256);
        send_pair(0, 0, 256, 0, 256, -256, 256, 256);
        send_pair(0, 0, 256, 0, 128, 0, 128, 512);
        send_pair(0, 0, 256, 0, 128, -512, 128, 0);
        // just missed on either side
        send_pair(0, 0, 256, 0, 257, -256, 257, 256);
        send_pair(0, 0, 256, 0, 100, 1, 100, 256);
        // extremes of the coordinate range
        send_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);
        send_pair(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX);
        send_pair(CMIN, CMIN, CMIN, CMAX, CMIN, 0, CMAX, 0);
        send_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        send_pair(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN);
        // negative quotients where truncation toward zero matters
        send_pair(0, 0, -7, -5, -3, 0, -3, -9);
        send_pair(5, 3, -2, -8, -9, 1, 7, -4);
        send_pair(-1, -1, 3, 7, 2, -5, -1, 6);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            kind = $urandom_range(0, 9);
            span = (kind < 2) ? ssi_pkg::COORD_WIDTH
                              : $urandom_range(3, ssi_pkg::COORD_WIDTH);
            a = rand_coord(span); b = rand_coord(span);
            c = rand_coord(span); d = rand_coord(span);
            e = rand_coord(span); f = rand_coord(span);
            g = rand_coord(span); h = rand_coord(span);
            case (kind)
                2: begin
                    // second segment a shifted copy of the first: parallel
                    g = e + (c - a); h = f + (d - b);
                end
                3: begin
                    // shared endpoint
                    if ($urandom_range(0, 1)) begin e = a; f = b; end
                    else begin g = c; h = d; end
                end
                4: begin
                    // crossing by construction: second runs through the midpoint
                    e = (a >>> 1) + (c >>> 1) - (g - ((a >>> 1) + (c >>> 1)));
                    f = (b >>> 1) + (d >>> 1) - (h - ((b >>> 1) + (d >>> 1)));
                end
                default: ;
            endcase
            send_pair(a, b, c, d, e, f, g, h);
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
